/* hdl/uds_pkg.sv */
package uds_pkg;

    // Alphabet and score widths
    localparam int unsigned ALPHABET_SIZE  = 13;
    localparam int unsigned SYMBOL_WIDTH   = 4;
    localparam int unsigned SUBST_WIDTH    = 5;
    localparam int unsigned SCORE_WIDTH    = 20;
    localparam int unsigned PRIOR_WIDTH    = 16;
    localparam int unsigned COMBINED_WIDTH = 22;

    // Stream word widths
    localparam int unsigned IN_DATA_WIDTH  = 24;
    localparam int unsigned OUT_DATA_WIDTH = 48;

    // Wildcard symbol; any code above it is scored as the wildcard
    localparam logic [SYMBOL_WIDTH-1:0] WILDCARD_CODE = 4'd12;

    localparam logic [SCORE_WIDTH-1:0] SCORE_CEILING = '1;

    typedef logic [SYMBOL_WIDTH-1:0]        symbol_t;
    typedef logic signed [SUBST_WIDTH-1:0]  subst_t;
    typedef logic [SCORE_WIDTH-1:0]         score_t;

    // Substitution table, row is the query symbol, column the target symbol
    localparam subst_t SUBST_ROM [ALPHABET_SIZE][ALPHABET_SIZE] = '{
        '{  5'sd8,  5'sd3, -5'sd2,  5'sd2, -5'sd2, -5'sd4, -5'sd6, -5'sd8, -5'sd2, -5'sd5,
           -5'sd7, -5'sd5, -5'sd1 },
        '{  5'sd3,  5'sd6,  5'sd0, -5'sd2, -5'sd4, -5'sd3, -5'sd3, -5'sd5, -5'sd5, -5'sd3,
           -5'sd5, -5'sd7, -5'sd1 },
        '{ -5'sd2,  5'sd0,  5'sd7,  5'sd4, -5'sd1,  5'sd1,  5'sd0, -5'sd3, -5'sd4, -5'sd2,
           -5'sd3, -5'sd5,  5'sd0 },
        '{  5'sd2, -5'sd2,  5'sd4,  5'sd8,  5'sd3, -5'sd2, -5'sd4, -5'sd7, -5'sd1, -5'sd3,
           -5'sd5, -5'sd2, -5'sd1 },
        '{ -5'sd2, -5'sd4, -5'sd1,  5'sd3,  5'sd6,  5'sd2, -5'sd4, -5'sd6,  5'sd0, -5'sd2,
           -5'sd3, -5'sd2, -5'sd3 },
        '{ -5'sd4, -5'sd3,  5'sd1, -5'sd2,  5'sd2,  5'sd6,  5'sd0, -5'sd3, -5'sd3, -5'sd1,
           -5'sd2, -5'sd4, -5'sd3 },
        '{ -5'sd6, -5'sd3,  5'sd0, -5'sd4, -5'sd4,  5'sd0,  5'sd3, -5'sd2, -5'sd4,  5'sd0,
           -5'sd1, -5'sd5, -5'sd2 },
        '{ -5'sd8, -5'sd5, -5'sd3, -5'sd7, -5'sd6, -5'sd3, -5'sd2,  5'sd0, -5'sd6, -5'sd2,
           -5'sd3, -5'sd8, -5'sd3 },
        '{ -5'sd2, -5'sd5, -5'sd4, -5'sd1,  5'sd0, -5'sd3, -5'sd4, -5'sd6,  5'sd6,  5'sd2,
           -5'sd2,  5'sd1, -5'sd3 },
        '{ -5'sd5, -5'sd3, -5'sd2, -5'sd3, -5'sd2, -5'sd1,  5'sd0, -5'sd2,  5'sd2,  5'sd5,
            5'sd0, -5'sd2, -5'sd2 },
        '{ -5'sd7, -5'sd5, -5'sd3, -5'sd5, -5'sd3, -5'sd2, -5'sd1, -5'sd3, -5'sd2,  5'sd0,
            5'sd6,  5'sd3,  5'sd0 },
        '{ -5'sd5, -5'sd7, -5'sd5, -5'sd2, -5'sd2, -5'sd4, -5'sd5, -5'sd8,  5'sd1, -5'sd2,
            5'sd3,  5'sd7, -5'sd2 },
        '{ -5'sd1, -5'sd1,  5'sd0, -5'sd1, -5'sd3, -5'sd3, -5'sd2, -5'sd3, -5'sd3, -5'sd2,
            5'sd0, -5'sd2,  5'sd9 }
    };

    // Map out-of-range codes onto the wildcard
    function automatic symbol_t clamp_symbol(input symbol_t code);
        return (code > WILDCARD_CODE) ? WILDCARD_CODE : code;
    endfunction

    // Table lookup for one aligned pair
    function automatic subst_t pair_score(input symbol_t query, input symbol_t target);
        symbol_t q;
        symbol_t t;
        q = clamp_symbol(query);
        t = clamp_symbol(target);
        return SUBST_ROM[q][t];
    endfunction

endpackage

/* hdl/ungapped_diagonal_score.sv */
// Ungapped local score of one alignment diagonal. Each input word carries one
// aligned residue pair (or none, flagged in tuser) of a 13-letter structural
// alphabet; the pair is scored from a fixed substitution table and added to a
// running score that is clamped at zero and saturates at 2^20-1, while the best
// running score is tracked. On the word marked by tlast one output word is
// produced with the best score and that score plus the prior score carried on
// the last word; both scores are then cleared for the next diagonal. One word
// is taken every clock cycle unless input is held back; the score update is a
// single combinational table lookup, add, clamp and compare. A result is
// registered in the output register when its last word leaves the input
// register. Input is held back only when a last word waits in the input
// register while an earlier result still sits unread in the output register.
module ungapped_diagonal_score
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [3:0] query_symbol, [7:4] target_symbol, [23:8] prior_score
    input  logic [uds_pkg::IN_DATA_WIDTH-1:0]    s_axis_tdata,
    // [0] pair_present
    input  logic                                 s_axis_tuser,
    input  logic                                 s_axis_tlast,

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [19:0] diagonal_score, [41:20] combined_score, [47:42] zero
    output logic [uds_pkg::OUT_DATA_WIDTH-1:0]   m_axis_tdata
);

    // Input register
    logic                                  in_valid_reg;
    uds_pkg::symbol_t                      query_reg;
    uds_pkg::symbol_t                      target_reg;
    logic                                  present_reg;
    logic                                  last_reg;
    logic signed [uds_pkg::PRIOR_WIDTH-1:0] prior_reg;

    // Diagonal state
    uds_pkg::score_t                       running_reg;
    uds_pkg::score_t                       best_reg;
    uds_pkg::score_t                       running_next;
    uds_pkg::score_t                       best_next;

    // Output register
    logic                                  out_valid_reg;
    uds_pkg::score_t                       diag_out_reg;
    logic [uds_pkg::COMBINED_WIDTH-1:0]    combined_out_reg;

    logic                                  in_advance;
    logic                                  in_accept;
    logic                                  out_take;
    uds_pkg::subst_t                       subst;
    logic signed [uds_pkg::SCORE_WIDTH+1:0] sum;
    logic signed [uds_pkg::COMBINED_WIDTH-1:0] combined;

    // The input register moves on unless a last word would overwrite an unread result
    assign out_take      = out_valid_reg & m_axis_tready;
    assign in_advance    = in_valid_reg & (~last_reg | ~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | in_advance;
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (in_advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            query_reg   <= s_axis_tdata[3:0];
            target_reg  <= s_axis_tdata[7:4];
            prior_reg   <= s_axis_tdata[23:8];
            present_reg <= s_axis_tuser;
            last_reg    <= s_axis_tlast;
        end
    end

    // Score update: table lookup, add, clamp at zero and the ceiling, track the best
    always_comb
    begin
        subst = uds_pkg::pair_score(query_reg, target_reg);
        sum   = $signed({2'b00, running_reg}) + (uds_pkg::SCORE_WIDTH + 2)'(subst);
        running_next = running_reg;
        if (present_reg)
        begin
            if (sum <= 0)
            begin
                running_next = '0;
            end
            else if (sum[uds_pkg::SCORE_WIDTH])
            begin
                running_next = uds_pkg::SCORE_CEILING;
            end
            else
            begin
                running_next = sum[uds_pkg::SCORE_WIDTH-1:0];
            end
        end
        best_next = (running_next > best_reg) ? running_next : best_reg;
        combined  = uds_pkg::COMBINED_WIDTH'(prior_reg)
                  + $signed({2'b00, best_next});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
            best_reg    <= '0;
        end
        else if (in_advance)
        begin
            if (last_reg)
            begin
                running_reg <= '0;
                best_reg    <= '0;
            end
            else
            begin
                running_reg <= running_next;
                best_reg    <= best_next;
            end
        end
    end

    // Result word for the end of a diagonal
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance && last_reg)
        begin
            diag_out_reg     <= best_next;
            combined_out_reg <= combined;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, combined_out_reg, diag_out_reg};

endmodule

/* hdl/uds_checker.sv */
module uds_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic [uds_pkg::IN_DATA_WIDTH-1:0]    s_axis_tdata,
    input  logic                                 s_axis_tuser,
    input  logic                                 s_axis_tlast,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [uds_pkg::OUT_DATA_WIDTH-1:0]   m_axis_tdata
);

    // The prior score is the combined score less the diagonal score
    logic signed [uds_pkg::COMBINED_WIDTH:0] prior_diff;

    assign prior_diff = $signed({m_axis_tdata[41], m_axis_tdata[41:20]})
                      - $signed({3'b000, m_axis_tdata[19:0]});

    // No result word right after reset
    assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result word shown right after reset");

    // A stalled result word stays and holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // Combined score differs from the diagonal score by a 16-bit prior
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> prior_diff >= -32768 && prior_diff <= 32767)
        else $error("combined score does not match diagonal score");

    // Padding bits of the result word are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:42] == 6'b0)
        else $error("result word padding not zero");

endmodule

bind ungapped_diagonal_score uds_checker u_uds_checker (.*);
